// File: sv/c2r_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2r_pkg
// Shared types, sizes and codes for the int8 2D convolution with ReLU.
// ----------------------------------------------------------------------------
package c2r_pkg;

  localparam int IMAGE_SIZE  = 32;
  localparam int KERNEL_SIZE = 3;
  localparam int KK          = KERNEL_SIZE * KERNEL_SIZE;

  // row/column counter width
  localparam int CW = (IMAGE_SIZE > 1) ? $clog2(IMAGE_SIZE) : 1;

  // pixel delay line: newest pixel sits one place ahead of tap 0
  localparam int TAP_RAW = (KERNEL_SIZE - 1) * IMAGE_SIZE + KERNEL_SIZE - 1;
  localparam int TAP_LEN = (TAP_RAW > 0) ? TAP_RAW : 1;

  localparam int PW  = 8;   // pixel / weight / bias width
  localparam int OIW = 10;  // output index width
  localparam int FW  = 7;   // feature width

  localparam logic [1:0] ACT_WEIGHT = 2'd0;
  localparam logic [1:0] ACT_BIAS   = 2'd1;
  localparam logic [1:0] ACT_PIXEL  = 2'd2;

  typedef struct packed {
    logic [1:0]           action;
    logic [3:0]           weight_index;
    logic signed [PW-1:0] weight_value;
    logic signed [PW-1:0] bias_value;
    logic signed [PW-1:0] pixel;
  } in_beat_t;

  typedef struct packed {
    logic [FW-1:0]  feature;
    logic [OIW-1:0] out_index;
    logic           last_of_frame;
  } out_beat_t;

  // one window in flight: remaining pixels and weights, bias, partial sum
  typedef struct packed {
    logic [KK-1:0][PW-1:0] px;
    logic [KK-1:0][PW-1:0] wt;
    logic [PW-1:0]         bias;
    logic [PW-1:0]         sum;
    logic [OIW-1:0]        out_index;
    logic                  last;
  } cell_data_t;

endpackage
`default_nettype wire

// File: sv/conv2d_int8_relu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// conv2d_int8_relu
// Valid-mode KxK convolution of a raster int8 pixel stream with bias and
// ReLU, built as a chain of MAC cells, one kernel tap per cell.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_data  (c2r_pkg::in_beat_t)
//  out     | output    | out_valid / out_ready| out_data (c2r_pkg::out_beat_t)
//
//  One beat per cycle, sustained unless a low out_ready backs the chain up.
//  Weight, bias and pixel beats all issue at one per cycle; a result passes
//  through the KK MAC cell registers, then the output register.
//  Reset clears kernel, bias, counters and all stage valids; the delay line
//  holds no reset and is only read once filled within the frame.
//  Each stage moves when the one after it is empty or moving, so in_ready
//  drops only when every stage holds a beat and out_ready is low.
// ----------------------------------------------------------------------------
module conv2d_int8_relu (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire c2r_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output c2r_pkg::out_beat_t     out_data
);

  logic                c_valid [c2r_pkg::KK+1];
  logic                c_ready [c2r_pkg::KK+1];
  c2r_pkg::cell_data_t c_data  [c2r_pkg::KK+1];

  c2r_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .win_valid (c_valid[0]),
    .win_data  (c_data[0]),
    .win_ready (c_ready[0])
  );

  for (genvar i = 0; i < c2r_pkg::KK; i++) begin : g_cell
    c2r_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[i]),
      .in_data   (c_data[i]),
      .in_ready  (c_ready[i]),
      .out_valid (c_valid[i+1]),
      .out_data  (c_data[i+1]),
      .out_ready (c_ready[i+1])
    );
  end

  c2r_tail u_tail (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid[c2r_pkg::KK]),
    .in_data   (c_data[c2r_pkg::KK]),
    .in_ready  (c_ready[c2r_pkg::KK]),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_ready (out_ready)
  );

endmodule
`default_nettype wire

// File: sv/c2r_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2r_front
// Input decode: kernel and bias registers, pixel delay line, raster counters
// and window capture for the MAC chain.
// ----------------------------------------------------------------------------
module c2r_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire c2r_pkg::in_beat_t in_data,
  output logic                   in_ready,
  output logic                   win_valid,
  output c2r_pkg::cell_data_t    win_data,
  input  wire logic              win_ready
);

  logic [c2r_pkg::TAP_LEN-1:0][c2r_pkg::PW-1:0] taps;
  logic [c2r_pkg::KK-1:0][c2r_pkg::PW-1:0]      kernel;
  logic [c2r_pkg::PW-1:0]                       bias;
  logic [c2r_pkg::CW-1:0]                       row_cnt;
  logic [c2r_pkg::CW-1:0]                       col_cnt;
  logic [c2r_pkg::OIW-1:0]                      oidx;

  logic accept;
  logic pix_acc;
  logic col_end;
  logic row_end;
  logic win_full;

  assign in_ready = win_ready;
  assign accept   = in_valid && in_ready;
  assign pix_acc  = accept && (in_data.action == c2r_pkg::ACT_PIXEL);
  assign col_end  = (col_cnt == c2r_pkg::CW'(c2r_pkg::IMAGE_SIZE - 1));
  assign row_end  = (row_cnt == c2r_pkg::CW'(c2r_pkg::IMAGE_SIZE - 1));
  assign win_full = (int'(row_cnt) >= c2r_pkg::KERNEL_SIZE - 1) &&
                    (int'(col_cnt) >= c2r_pkg::KERNEL_SIZE - 1) &&
                    (c2r_pkg::KERNEL_SIZE <= c2r_pkg::IMAGE_SIZE);

  assign win_valid = pix_acc && win_full;

  // window entry m*K+n sits (K-1-m) rows and (K-1-n) columns behind the new pixel
  always_comb begin
    int p;
    win_data = '0;
    for (int m = 0; m < c2r_pkg::KERNEL_SIZE; m++) begin
      for (int n = 0; n < c2r_pkg::KERNEL_SIZE; n++) begin
        p = (c2r_pkg::KERNEL_SIZE - 1 - m) * c2r_pkg::IMAGE_SIZE +
            (c2r_pkg::KERNEL_SIZE - 1 - n);
        if (p == 0) begin
          win_data.px[m * c2r_pkg::KERNEL_SIZE + n] = in_data.pixel;
        end else begin
          win_data.px[m * c2r_pkg::KERNEL_SIZE + n] = taps[p - 1];
        end
      end
    end
    win_data.wt        = kernel;
    win_data.bias      = bias;
    win_data.sum       = '0;
    win_data.out_index = oidx;
    win_data.last      = row_end && col_end;
  end

  // delay line holds image data only, no reset needed
  always_ff @(posedge clk) begin
    if (pix_acc) begin
      taps[0] <= in_data.pixel;
      for (int j = 1; j < c2r_pkg::TAP_LEN; j++) begin
        taps[j] <= taps[j - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel  <= '0;
      bias    <= '0;
      row_cnt <= '0;
      col_cnt <= '0;
      oidx    <= '0;
    end else if (accept) begin
      unique case (in_data.action)
        c2r_pkg::ACT_WEIGHT: begin
          for (int j = 0; j < c2r_pkg::KK; j++) begin
            if (int'(in_data.weight_index) == j) begin
              kernel[j] <= in_data.weight_value;
            end
          end
        end
        c2r_pkg::ACT_BIAS: begin
          bias <= in_data.bias_value;
        end
        c2r_pkg::ACT_PIXEL: begin
          if (col_end) begin
            col_cnt <= '0;
            row_cnt <= row_end ? '0 : row_cnt + 1'b1;
          end else begin
            col_cnt <= col_cnt + 1'b1;
          end
          if (win_full) begin
            oidx <= (row_end && col_end) ? '0 : oidx + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (int'(col_cnt) < c2r_pkg::IMAGE_SIZE) && (int'(row_cnt) < c2r_pkg::IMAGE_SIZE))
    else $error("raster counter out of range");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (pix_acc && row_end && col_end) |=> (row_cnt == '0 && col_cnt == '0))
    else $error("counters did not wrap at frame end");

  a_idx_restart: assert property (@(posedge clk) disable iff (rst)
    (win_valid && win_data.last) |=> (oidx == '0))
    else $error("output index did not restart after last window");

endmodule
`default_nettype wire

// File: sv/c2r_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2r_cell
// One MAC cell: multiplies the head pixel by the head weight, adds the
// product >>> 8 to the partial sum and shifts the rest of the window along.
// ----------------------------------------------------------------------------
module c2r_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire c2r_pkg::cell_data_t in_data,
  output logic                     in_ready,
  output logic                     out_valid,
  output c2r_pkg::cell_data_t      out_data,
  input  wire logic                out_ready
);

  logic signed [2*c2r_pkg::PW-1:0] prod;
  c2r_pkg::cell_data_t             data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    prod      = $signed(in_data.px[0]) * $signed(in_data.wt[0]);
    data_next = in_data;
    // upper byte of the product is the floor shift; sum wraps mod 256
    data_next.sum = in_data.sum + prod[2*c2r_pkg::PW-1:c2r_pkg::PW];
    for (int j = 0; j < c2r_pkg::KK - 1; j++) begin
      data_next.px[j] = in_data.px[j + 1];
      data_next.wt[j] = in_data.wt[j + 1];
    end
    data_next.px[c2r_pkg::KK - 1] = '0;
    data_next.wt[c2r_pkg::KK - 1] = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/c2r_tail.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2r_tail
// Output register: adds the bias, applies ReLU and holds the result beat.
// ----------------------------------------------------------------------------
module c2r_tail (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire c2r_pkg::cell_data_t in_data,
  output logic                     in_ready,
  output logic                     out_valid,
  output c2r_pkg::out_beat_t       out_data,
  input  wire logic                out_ready
);

  logic [c2r_pkg::PW-1:0] v;
  c2r_pkg::out_beat_t     beat_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    v = in_data.sum + in_data.bias;
    beat_next.feature       = v[c2r_pkg::PW-1] ? '0 : v[c2r_pkg::FW-1:0];
    beat_next.out_index     = in_data.out_index;
    beat_next.last_of_frame = in_data.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= beat_next;
    end
  end

endmodule
`default_nettype wire

// File: tb/tb_conv2d_int8_relu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_conv2d_int8_relu
// Self-checking bench for the int8 KxK convolution with bias and ReLU.
// A queue of input beats (kernel and bias writes, raster pixels, ignored
// codes) feeds a driver. A monitor keeps a golden copy of kernel, bias,
// frame and counters and checks every output beat in order. Both sides
// throttle at random, and one long output stall backs the pipe up.
// ----------------------------------------------------------------------------
module tb_conv2d_int8_relu;
  import c2r_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;  // unused code, dropped by the block
  localparam int IBW       = $bits(in_beat_t);
  localparam int OUT_SIDE  = IMAGE_SIZE - KERNEL_SIZE + 1;
  localparam int N_RAND    = 1250;
  localparam int HOLD_LEN  = 300;
  localparam int TAIL      = 4 * (KK + 1);
  localparam int LIMIT     = 200000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  conv2d_int8_relu u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // stimulus and bookkeeping
  in_beat_t  pend_beats[$];
  out_beat_t want_q[$];
  int        n_total = 1;
  int        n_sent = 0;
  int        n_err = 0;
  int        hold_left = 0;
  logic      hold_done = 1'b0;
  int        cycles = 0;

  // golden state
  logic signed [PW-1:0] kern_w [KK];
  logic signed [PW-1:0] kern_bias;
  logic signed [PW-1:0] frame_px [IMAGE_SIZE][IMAGE_SIZE];
  int                   row_q;
  int                   col_q;

  initial begin
    foreach (kern_w[i]) kern_w[i] = '0;
    kern_bias = '0;
    row_q = 0;
    col_q = 0;
  end

  // three throttle phases by progress through the stream
  function automatic int phase_now();
    return (n_sent * 3) / n_total;
  endfunction

  function automatic int send_idle_pct();
    case (phase_now())
      0:       return 12;
      1:       return 55;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct();
    case (phase_now())
      0:       return 55;
      1:       return 12;
      default: return 0;
    endcase
  endfunction

  // unused fields carry random bits so every bit toggles
  function automatic in_beat_t mk_beat(logic [1:0] act);
    in_beat_t b;
    b = in_beat_t'(IBW'($urandom));
    b.action = act;
    return b;
  endfunction

  function automatic in_beat_t mk_weight(logic [3:0] idx, logic signed [PW-1:0] val);
    in_beat_t b;
    b = mk_beat(ACT_WEIGHT);
    b.weight_index = idx;
    b.weight_value = val;
    return b;
  endfunction

  function automatic in_beat_t mk_bias(logic signed [PW-1:0] val);
    in_beat_t b;
    b = mk_beat(ACT_BIAS);
    b.bias_value = val;
    return b;
  endfunction

  function automatic in_beat_t mk_pixel(logic signed [PW-1:0] val);
    in_beat_t b;
    b = mk_beat(ACT_PIXEL);
    b.pixel = val;
    return b;
  endfunction

  // apply one accepted beat to the golden state, queue the feature it yields
  task automatic conv_step(input in_beat_t b);
    logic signed [2*PW-1:0] prod;
    logic [PW-1:0]          acc;
    int                     r0;
    int                     c0;
    out_beat_t              e;
    case (b.action)
      ACT_WEIGHT: begin
        if (b.weight_index < KK) kern_w[b.weight_index] = b.weight_value;
      end
      ACT_BIAS: kern_bias = b.bias_value;
      ACT_PIXEL: begin
        frame_px[row_q][col_q] = b.pixel;
        if (row_q >= KERNEL_SIZE - 1 && col_q >= KERNEL_SIZE - 1) begin
          r0 = row_q - (KERNEL_SIZE - 1);
          c0 = col_q - (KERNEL_SIZE - 1);
          acc = kern_bias;
          for (int m = 0; m < KERNEL_SIZE; m++) begin
            for (int n = 0; n < KERNEL_SIZE; n++) begin
              prod = frame_px[r0 + m][c0 + n] * kern_w[m * KERNEL_SIZE + n];
              // upper byte = floor(prod / 256), wrapped to 8 bits
              acc = acc + prod[2*PW-1:PW];
            end
          end
          e.feature       = acc[PW-1] ? '0 : acc[FW-1:0];
          e.out_index     = OIW'(r0 * OUT_SIDE + c0);
          e.last_of_frame = (row_q == IMAGE_SIZE - 1) && (col_q == IMAGE_SIZE - 1);
          want_q.push_back(e);
        end
        if (col_q + 1 >= IMAGE_SIZE) begin
          col_q = 0;
          row_q = (row_q + 1 >= IMAGE_SIZE) ? 0 : row_q + 1;
        end else begin
          col_q = col_q + 1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_err(input string what, input out_beat_t exp_b, input out_beat_t got_b);
    if (n_err < 10) begin
      $display("[%0d] %s: exp feature=%0d index=%0d last=%0b, got feature=%0d index=%0d last=%0b",
               cycles, what, exp_b.feature, exp_b.out_index, exp_b.last_of_frame,
               got_b.feature, got_b.out_index, got_b.last_of_frame);
    end
    n_err = n_err + 1;
  endtask

  // driver: next beat goes out once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) n_sent <= n_sent + 1;
      if (pend_beats.size() != 0 &&
          (hold_left != 0 || $urandom_range(99) >= send_idle_pct())) begin
        in_valid <= 1'b1;
        in_data  <= pend_beats.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: check output beat, then fold in any accepted input beat
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          note_err("unexpected beat", '0, out_data);
        end else if (out_data.feature !== want_q[0].feature ||
                     out_data.out_index !== want_q[0].out_index ||
                     out_data.last_of_frame !== want_q[0].last_of_frame) begin
          note_err("mismatch", want_q[0], out_data);
          void'(want_q.pop_front());
        end else begin
          void'(want_q.pop_front());
        end
      end
      if (in_valid && in_ready) conv_step(in_data);

      // one long output stall midway so the input side backs up
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && n_sent >= n_total / 2) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct());
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int                   n_items;
    int                   n_px;
    int                   roll;
    logic signed [PW-1:0] v;
    logic [3:0]           idx;

    // directed: a weight on every tap, some full-scale, dropped indexes, bias
    // extremes, an unused code, then extreme pixels to open the frame
    pend_beats.push_back(mk_weight(4'd0, -8'sd128));
    pend_beats.push_back(mk_weight(4'd1, 8'sd127));
    pend_beats.push_back(mk_weight(4'd2, -8'sd1));
    pend_beats.push_back(mk_weight(4'd3, 8'sd1));
    pend_beats.push_back(mk_weight(4'd4, 8'sd64));
    pend_beats.push_back(mk_weight(4'd5, -8'sd64));
    pend_beats.push_back(mk_weight(4'd6, 8'sd100));
    pend_beats.push_back(mk_weight(4'd7, -8'sd100));
    pend_beats.push_back(mk_weight(4'd8, 8'sd127));
    pend_beats.push_back(mk_weight(4'd9, 8'sd55));
    pend_beats.push_back(mk_weight(4'd15, -8'sd7));
    pend_beats.push_back(mk_bias(-8'sd128));
    pend_beats.push_back(mk_bias(8'sd127));
    pend_beats.push_back(mk_bias(8'sd5));
    pend_beats.push_back(mk_beat(ACT_NONE));
    n_px = 0;
    for (int i = 0; i < 10; i++) begin
      pend_beats.push_back(mk_pixel((i % 2) ? 8'sd127 : -8'sd128));
      n_px++;
    end

    // random: mostly pixels, kernel/bias rewrites mid-frame, some noise;
    // run past one frame end so the counters wrap
    n_items = 0;
    while (n_items < N_RAND || n_px < IMAGE_SIZE * IMAGE_SIZE + 96) begin
      roll = $urandom_range(99);
      if (roll < 84) begin
        v = PW'($urandom);
        if ($urandom_range(7) == 0) v = $urandom_range(1) ? 8'sd127 : -8'sd128;
        pend_beats.push_back(mk_pixel(v));
        n_px++;
      end else if (roll < 92) begin
        idx = ($urandom_range(7) == 0) ? 4'($urandom_range(15, KK)) : 4'($urandom_range(KK - 1));
        pend_beats.push_back(mk_weight(idx, PW'($urandom)));
      end else if (roll < 97) begin
        pend_beats.push_back(mk_bias(PW'($urandom)));
      end else begin
        pend_beats.push_back(mk_beat(ACT_NONE));
      end
      n_items++;
    end
    n_total = pend_beats.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pend_beats.size() != 0 || in_valid || want_q.size() != 0) @(negedge clk);
    repeat (TAIL) @(negedge clk);

    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
